/* hw/rtl/rcts_pkg.sv */
// shared types, constants and codes for the rotated circular tilemap sampler
package rcts_pkg;

  // block constants
  localparam int RADIUS       = 64;
  localparam int SCALE_LOG2   = 3;
  localparam int SCALE        = 1 << SCALE_LOG2;
  localparam int MAP_DIM_MAX  = 64;
  localparam int BORDER_WIDTH = 3;
  localparam int INNER        = RADIUS - BORDER_WIDTH;

  // field widths
  localparam int CELL_W = 6;
  localparam int KIND_W = 2;
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 7;
  localparam int POS_W  = 14;
  localparam int TRIG_W = 16;
  localparam int CLS_W  = 2;
  localparam int IDX_CFG_W = 3;

  // datapath widths
  localparam int DIST_W     = 2 * PIX_W + 1;
  localparam int PROD_W     = PIX_W + TRIG_W;
  localparam int BASE_SHIFT = 6 + SCALE_LOG2;
  localparam int NX_W       = POS_W + BASE_SHIFT + 3;
  localparam int DEN_LOG2   = SCALE_LOG2 + 14;
  localparam int COL_W      = NX_W - DEN_LOG2;
  localparam int IDX_W      = $clog2(MAP_DIM_MAX);
  localparam int CELLS      = MAP_DIM_MAX * MAP_DIM_MAX;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam logic signed [NX_W-1:0] NEG_DEN = -(NX_W'(1) << DEN_LOG2);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // cell kinds as stored
  localparam logic [KIND_W-1:0] KIND_VOID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;

  // configuration register indexes
  localparam logic [IDX_CFG_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [IDX_CFG_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [IDX_CFG_W-1:0] CFG_PLAYER_X   = 3'd2;
  localparam logic [IDX_CFG_W-1:0] CFG_PLAYER_Y   = 3'd3;
  localparam logic [IDX_CFG_W-1:0] CFG_COS_ANGLE  = 3'd4;
  localparam logic [IDX_CFG_W-1:0] CFG_SIN_ANGLE  = 3'd5;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [CLS_W-1:0] {
    CLASS_VOID   = 2'd0,
    CLASS_WALL   = 2'd1,
    CLASS_FLOOR  = 2'd2,
    CLASS_BORDER = 2'd3
  } class_t;

  typedef struct packed {
    logic [DIM_W-1:0]         map_width;
    logic [DIM_W-1:0]         map_height;
    logic [POS_W-1:0]         player_x;
    logic [POS_W-1:0]         player_y;
    logic signed [TRIG_W-1:0] cos_angle;
    logic signed [TRIG_W-1:0] sin_angle;
  } cfg_t;

  // one classified request on its way to the back end
  typedef struct packed {
    cmd_t              op;
    logic              hit;     // write: inside store, render: inside map
    logic              drawn;
    logic              border;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
  } job_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } axis_t;

endpackage

/* hw/rtl/rcts_front.sv */
// front end: accepts requests, tests the disc, rotates and maps to a cell address
module rcts_front import rcts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [CELL_W-1:0]       cell_col,
  input  logic [CELL_W-1:0]       cell_row,
  input  logic [KIND_W-1:0]       cell_kind,
  input  logic signed [PIX_W-1:0] pixel_dx,
  input  logic signed [PIX_W-1:0] pixel_dy,
  output logic                    job_valid,
  input  logic                    job_ready,
  output job_t                    job
);

  // stage a: squares and rotation products
  logic signed [2*PIX_W-1:0] sq_x, sq_y;
  logic [DIST_W-1:0]         dist_sq;
  logic signed [PROD_W-1:0]  xc, ys, xs, yc;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      wr_ok;

  logic                     a_valid;
  cmd_t                     a_op;
  logic [KIND_W-1:0]        a_kind;
  logic [ADDR_W-1:0]        a_addr;
  logic                     a_ok;
  logic                     a_drawn;
  logic                     a_border;
  logic signed [PROD_W-1:0] a_xc, a_ys, a_xs, a_yc;

  // stage b: sums and cell lookup address
  logic signed [NX_W-1:0] base_x, base_y, nx, ny;
  logic [DIM_W-1:0]       dim_w, dim_h;
  axis_t                  ax, ay;
  job_t                   b_next;
  logic                   b_valid;
  job_t                   b_job;

  logic b_space, a_space;

  function automatic axis_t map_axis(input logic signed [NX_W-1:0] n,
                                     input logic [DIM_W-1:0] dim);
    axis_t            r;
    logic [COL_W-1:0] c;
    c = n[NX_W-1] ? '0 : n[NX_W-1:DEN_LOG2];
    // truncation toward zero sends (-1, 0) to cell zero
    r.ok  = (!n[NX_W-1] || (n > NEG_DEN)) && (c < COL_W'(dim));
    r.idx = IDX_W'(c);
    return r;
  endfunction

  assign b_space  = !b_valid || job_ready;
  assign a_space  = !a_valid || b_space;
  assign in_ready = a_space;

  always_comb begin
    sq_x    = (2*PIX_W)'(pixel_dx) * (2*PIX_W)'(pixel_dx);
    sq_y    = (2*PIX_W)'(pixel_dy) * (2*PIX_W)'(pixel_dy);
    dist_sq = DIST_W'($unsigned(sq_x)) + DIST_W'($unsigned(sq_y));
    xc      = PROD_W'(pixel_dx) * PROD_W'(cfg.cos_angle);
    ys      = PROD_W'(pixel_dy) * PROD_W'(cfg.sin_angle);
    xs      = PROD_W'(pixel_dx) * PROD_W'(cfg.sin_angle);
    yc      = PROD_W'(pixel_dy) * PROD_W'(cfg.cos_angle);
    wr_ok   = (32'(cell_col) < MAP_DIM_MAX) && (32'(cell_row) < MAP_DIM_MAX);
    wr_addr = ADDR_W'(cell_row) * ADDR_W'(MAP_DIM_MAX) + ADDR_W'(cell_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_space) begin
      a_valid <= in_valid;
    end
    if (a_space) begin
      a_op     <= cmd_t'(in_command);
      a_kind   <= cell_kind;
      a_addr   <= wr_addr;
      a_ok     <= wr_ok;
      a_drawn  <= dist_sq <= DIST_W'(RADIUS * RADIUS);
      a_border <= dist_sq > DIST_W'(INNER * INNER);
      a_xc     <= xc;
      a_ys     <= ys;
      a_xs     <= xs;
      a_yc     <= yc;
    end
  end

  always_comb begin
    base_x = $signed(NX_W'(cfg.player_x) << BASE_SHIFT);
    base_y = $signed(NX_W'(cfg.player_y) << BASE_SHIFT);
    nx     = base_x + NX_W'(a_xc) - NX_W'(a_ys);
    ny     = base_y + NX_W'(a_xs) + NX_W'(a_yc);
    dim_w  = (cfg.map_width > DIM_W'(MAP_DIM_MAX)) ? DIM_W'(MAP_DIM_MAX) : cfg.map_width;
    dim_h  = (cfg.map_height > DIM_W'(MAP_DIM_MAX)) ? DIM_W'(MAP_DIM_MAX) : cfg.map_height;
    ax     = map_axis(nx, dim_w);
    ay     = map_axis(ny, dim_h);

    b_next.op     = a_op;
    b_next.kind   = a_kind;
    b_next.drawn  = a_drawn;
    b_next.border = a_border;
    if (a_op == CMD_RENDER) begin
      b_next.hit  = ax.ok && ay.ok;
      b_next.addr = ADDR_W'(ay.idx) * ADDR_W'(MAP_DIM_MAX) + ADDR_W'(ax.idx);
    end else begin
      b_next.hit  = a_ok;
      b_next.addr = a_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_space) begin
      b_valid <= a_valid;
    end
    if (b_space) begin
      b_job <= b_next;
    end
  end

  assign job_valid = b_valid;
  assign job       = b_job;

endmodule

/* hw/rtl/rcts_queue.sv */
// short register queue between the front and back ends
module rcts_queue import rcts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

/* hw/rtl/rcts_back.sv */
// back end: cell store, registered lookup and output register
module rcts_back import rcts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             res_valid,
  input  logic             res_ready,
  output logic             res_drawn,
  output logic [CLS_W-1:0] res_class
);

  logic [KIND_W-1:0] cells [CELLS];
  logic [KIND_W-1:0] rd_kind;
  logic              r_valid;
  job_t              r_job;
  logic              r_move, pop;
  class_t            cls;

  assign r_move    = r_valid && (!res_valid || res_ready);
  assign pop       = job_valid && (!r_valid || r_move);
  assign job_ready = !r_valid || r_move;

  // cell store, read data held while the lookup stage stalls
  always_ff @(posedge clk) begin
    if (pop && job.op == CMD_WRITE && job.hit) begin
      cells[job.addr] <= job.kind;
    end
    if (pop) begin
      rd_kind <= cells[job.addr];
      r_job   <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid <= job.op == CMD_RENDER;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
  end

  always_comb begin
    if (!r_job.drawn) begin
      cls = CLASS_VOID;
    end else if (r_job.border) begin
      cls = CLASS_BORDER;
    end else if (!r_job.hit) begin
      cls = CLASS_VOID;
    end else begin
      case (rd_kind)
        KIND_VOID: cls = CLASS_VOID;
        KIND_WALL: cls = CLASS_WALL;
        default:   cls = CLASS_FLOOR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (r_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (r_move) begin
      res_drawn <= r_job.drawn;
      res_class <= cls;
    end
  end

endmodule

/* hw/rtl/rotated_circular_tilemap_sampler_unit.sv */
// top level of the rotated circular tilemap sampler
// Takes one request per cycle while s_tready is high. A write request
// (s_tuser = 0) stores a 2-bit cell kind in a 64 x 64 map and gives no
// result; a render request (s_tuser = 1) gives one result: whether the
// pixel offset lies in the minimap disc, and the class of what shows there
// (void, wall, floor or the white border ring). Rate: one request per cycle
// sustained while the result side does not stall, throughput set by the
// single-port cell store, which serves one write or one lookup each cycle.
// A result passes five registers (two front stages, the queue, the store read
// and the output register). Cells that were never written read back as
// whatever the store holds. The user must see that configuration is written
// only while idle; the block does not enforce it. cfg_ready is always high.
module rotated_circular_tilemap_sampler_unit import rcts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [5:0] cell_col, [11:6] cell_row, [13:12] cell_kind,
  // [21:14] pixel_dx, [29:22] pixel_dy, [31:30] zero
  input  logic [31:0]          s_tdata,
  // [0] command
  input  logic                 s_tuser,
  // result channel
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [1:0] pixel_class, [7:2] zero
  output logic [7:0]           m_tdata,
  // [0] pixel_drawn
  output logic                 m_tuser,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_CFG_W-1:0] cfg_index,
  input  logic [TRIG_W-1:0]    cfg_data
);

  cfg_t             cfg;
  logic             job_valid, job_ready;
  job_t             job;
  logic             q_valid, q_ready;
  job_t             q_job;
  logic [CLS_W-1:0] res_class;

  // configuration registers, index decode follows the register list
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= DIM_W'(MAP_DIM_MAX);
      cfg.map_height <= DIM_W'(MAP_DIM_MAX);
      cfg.player_x   <= '0;
      cfg.player_y   <= '0;
      cfg.cos_angle  <= TRIG_W'(16384);
      cfg.sin_angle  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  cfg.map_width  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: cfg.map_height <= cfg_data[DIM_W-1:0];
        CFG_PLAYER_X:   cfg.player_x   <= cfg_data[POS_W-1:0];
        CFG_PLAYER_Y:   cfg.player_y   <= cfg_data[POS_W-1:0];
        CFG_COS_ANGLE:  cfg.cos_angle  <= $signed(cfg_data);
        CFG_SIN_ANGLE:  cfg.sin_angle  <= $signed(cfg_data);
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // front end: disc test, rotation and address mapping
  rcts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .cell_col   (s_tdata[5:0]),
    .cell_row   (s_tdata[11:6]),
    .cell_kind  (s_tdata[13:12]),
    .pixel_dx   ($signed(s_tdata[21:14])),
    .pixel_dy   ($signed(s_tdata[29:22])),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  // decouples the front stages from stalls on the result side
  rcts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  // back end: store writes and lookups in request order
  rcts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_drawn (m_tuser),
    .res_class (res_class)
  );

  assign m_tdata = {6'b0, res_class};

endmodule

/* tb/sv/tb_top.sv */
// testbench for the rotated circular tilemap sampler unit
module tb_top;
  import rcts_pkg::*;

  // exact divisor of the rotated, scaled offset (SCALE * 1.0 in Q1.14)
  localparam longint DEN = longint'(SCALE) * 16384;
  // cells a disc pixel can reach from the player cell, for any cos/sin pair
  localparam int REACH = 12;
  localparam int RANDOM_ITEMS = 500;
  // long enough for the block to empty out, plus some slack
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 150;
  localparam longint RUN_LIMIT = 64'd20_000_000;

  // cell kinds the package does not name
  localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic   drawn;
    class_t cls;
  } pixel_result_t;

  // where one offset lands under the current view
  typedef struct packed {
    logic              drawn;
    logic              border;
    logic              in_map;
    logic [ADDR_W-1:0] addr;
  } pixel_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_CFG_W-1:0] cfg_index = '0;
  logic [TRIG_W-1:0]    cfg_data = '0;

  // shadow of the block: view registers and the cell store
  cfg_t              view_cfg;
  logic [KIND_W-1:0] map_shadow [CELLS];
  bit                map_known [CELLS];

  // results still owed by the block, oldest first
  pixel_result_t pending_pixels [$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  hold_req = 0;

  rotated_circular_tilemap_sampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint dim_used(input logic [DIM_W-1:0] reg_val);
    return (reg_val > MAP_DIM_MAX) ? longint'(MAP_DIM_MAX) : longint'(reg_val);
  endfunction

  // rotate the offset, scale it down, add the player position and truncate; test the disc too
  function automatic pixel_view_t view_pixel(input logic signed [PIX_W-1:0] dx,
                                             input logic signed [PIX_W-1:0] dy);
    pixel_view_t v;
    longint sx, sy, c, s, dsq, nx, ny, mx, my;
    sx = dx;
    sy = dy;
    c = $signed(view_cfg.cos_angle);
    s = $signed(view_cfg.sin_angle);
    dsq = sx * sx + sy * sy;
    nx = longint'(view_cfg.player_x) * 64 * SCALE + sx * c - sy * s;
    ny = longint'(view_cfg.player_y) * 64 * SCALE + sx * s + sy * c;
    // longint division truncates toward zero, so (-1, 0) lands on cell 0
    mx = nx / DEN;
    my = ny / DEN;
    v.drawn = dsq <= RADIUS * RADIUS;
    v.border = dsq > INNER * INNER;
    v.in_map = mx >= 0 && my >= 0 && mx < dim_used(view_cfg.map_width) &&
               my < dim_used(view_cfg.map_height);
    v.addr = v.in_map ? ADDR_W'(my * MAP_DIM_MAX + mx) : '0;
    return v;
  endfunction

  function automatic pixel_result_t classify_pixel(input pixel_view_t v);
    pixel_result_t r;
    r.drawn = v.drawn;
    if (!v.drawn) begin
      r.cls = CLASS_VOID;
    end else if (v.border) begin
      // ring wins over whatever the cell holds
      r.cls = CLASS_BORDER;
    end else if (!v.in_map) begin
      r.cls = CLASS_VOID;
    end else begin
      case (map_shadow[v.addr])
        KIND_VOID: r.cls = CLASS_VOID;
        KIND_WALL: r.cls = CLASS_WALL;
        default:   r.cls = CLASS_FLOOR;  // floor and the spare kind
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: drawn %0b data %h",
                                m_tuser, m_tdata));
      end else begin
        want = pending_pixels.pop_front();
        if (m_tuser !== want.drawn)
          flag_mismatch($sformatf("pixel_drawn %b, predicted %b", m_tuser, want.drawn));
        if (m_tdata !== {{(8 - CLS_W){1'b0}}, want.cls})
          flag_mismatch($sformatf("pixel_class data %h, predicted class %s",
                                  m_tdata, want.cls.name()));
      end
    end
  end

  // result side ready: random stall bursts, plus a long hold-off on demand
  initial begin : result_sink
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic logic signed [PIX_W-1:0] rand_offset();
    int t;
    t = int'($urandom_range(0, 128)) - 64;
    return t[PIX_W-1:0];
  endfunction

  // tdata: col, row, kind, dx, dy from bit 0 up, zero filled to 32 bits
  function automatic logic [31:0] pack_request(input logic [CELL_W-1:0] col,
                                               input logic [CELL_W-1:0] row,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [PIX_W-1:0] dx,
                                               input logic [PIX_W-1:0] dy);
    return {2'b00, dy, dx, kind, row, col};
  endfunction

  // offer one request, hold it until taken, then update the shadow
  task automatic push_request(input cmd_t op, input logic [31:0] data);
    logic [ADDR_W-1:0] addr;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == CMD_WRITE) begin
      addr = {data[11:6], data[5:0]};
      map_shadow[addr] = data[13:12];
      map_known[addr] = 1'b1;
    end else begin
      pending_pixels.push_back(classify_pixel(view_pixel(data[21:14], data[29:22])));
    end
  endtask

  task automatic send_cell_write(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                                 input logic [KIND_W-1:0] kind);
    push_request(CMD_WRITE, pack_request(col, row, kind, rand_offset(), rand_offset()));
  endtask

  task automatic send_render_at(input logic signed [PIX_W-1:0] dx,
                                input logic signed [PIX_W-1:0] dy);
    pixel_view_t v;
    v = view_pixel(dx, dy);
    // never look up a cell that was not written: fall back to a pixel off the disc
    if (v.drawn && v.in_map && !map_known[v.addr]) begin
      dx = 8'sd64;
      dy = 8'sd64;
    end
    push_request(CMD_RENDER, pack_request(CELL_W'($urandom), CELL_W'($urandom),
                                          KIND_W'($urandom), dx, dy));
  endtask

  // random offset from -64 to 64 per axis, redrawn while it hits an unwritten cell
  task automatic send_render();
    logic signed [PIX_W-1:0] dx, dy;
    pixel_view_t v;
    int tries;
    tries = 0;
    do begin
      dx = rand_offset();
      dy = rand_offset();
      v = view_pixel(dx, dy);
      tries++;
    end while (v.drawn && v.in_map && !map_known[v.addr] && tries < 16);
    send_render_at(dx, dy);
  endtask

  // let the block empty out; writes give no result, so wait out the pipeline too
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // configuration write, valid left high so back-to-back writes need no gap
  task automatic set_reg(input logic [IDX_CFG_W-1:0] idx, input logic [TRIG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAP_WIDTH:  view_cfg.map_width = value[DIM_W-1:0];
      CFG_MAP_HEIGHT: view_cfg.map_height = value[DIM_W-1:0];
      CFG_PLAYER_X:   view_cfg.player_x = value[POS_W-1:0];
      CFG_PLAYER_Y:   view_cfg.player_y = value[POS_W-1:0];
      CFG_COS_ANGLE:  view_cfg.cos_angle = value;
      CFG_SIN_ANGLE:  view_cfg.sin_angle = value;
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic load_view(input int w, input int h, input int px, input int py,
                           input int c, input int s);
    set_reg(CFG_MAP_WIDTH, TRIG_W'(w));
    set_reg(CFG_MAP_HEIGHT, TRIG_W'(h));
    set_reg(CFG_PLAYER_X, TRIG_W'(px));
    set_reg(CFG_PLAYER_Y, TRIG_W'(py));
    set_reg(CFG_COS_ANGLE, TRIG_W'(c));
    set_reg(CFG_SIN_ANGLE, TRIG_W'(s));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // write every unwritten cell the disc can reach from the player, random kinds
  task automatic fill_window();
    int wuse, huse, pcx, pcy, c0, c1, r0, r1;
    wuse = int'(dim_used(view_cfg.map_width));
    huse = int'(dim_used(view_cfg.map_height));
    pcx = int'(view_cfg.player_x >> 8);
    pcy = int'(view_cfg.player_y >> 8);
    c0 = (pcx - REACH < 0) ? 0 : pcx - REACH;
    r0 = (pcy - REACH < 0) ? 0 : pcy - REACH;
    c1 = (pcx + REACH > wuse - 1) ? wuse - 1 : pcx + REACH;
    r1 = (pcy + REACH > huse - 1) ? huse - 1 : pcy + REACH;
    for (int r = r0; r <= r1; r++) begin
      for (int col = c0; col <= c1; col++) begin
        if (!map_known[r * MAP_DIM_MAX + col])
          send_cell_write(CELL_W'(col), CELL_W'(r), KIND_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset view: player at 0,0, no rotation, so cell = offset / 8 truncated
  task automatic test_directed_lookup();
    send_cell_write(6'd0, 6'd0, KIND_WALL);
    send_cell_write(6'd1, 6'd0, KIND_SPARE);  // spare kind reads as floor
    send_cell_write(6'd7, 6'd0, KIND_FLOOR);
    send_cell_write(6'd63, 6'd63, KIND_WALL); // far corner, both index fields all ones
    send_render_at(8'sd0, 8'sd0);
    send_render_at(8'sd7, 8'sd0);
    send_render_at(-8'sd7, 8'sd0);    // small negative sum truncates onto cell 0
    send_render_at(-8'sd8, 8'sd0);    // column -1, off the map
    send_render_at(8'sd0, -8'sd7);
    send_render_at(8'sd0, -8'sd8);    // row -1, off the map
    send_render_at(8'sd8, 8'sd0);
    send_render_at(8'sd60, 8'sd0);
    send_render_at(8'sd61, 8'sd0);    // last radius inside the ring
    send_render_at(8'sd62, 8'sd0);    // first radius in the ring
    send_render_at(8'sd64, 8'sd0);    // rim of the disc
    send_render_at(-8'sd64, 8'sd0);
    send_render_at(8'sd0, -8'sd64);
    send_render_at(8'sd0, 8'sd64);
    send_render_at(8'sd45, 8'sd45);   // ring on the diagonal
    send_render_at(8'sd46, 8'sd46);   // just off the disc
    send_render_at(-8'sd64, -8'sd64); // corner, off the disc
    send_cell_write(6'd0, 6'd0, KIND_VOID);
    send_render_at(8'sd0, 8'sd0);
  endtask

  // zero sizes, oversized registers, player at the far corner, full-scale angles
  task automatic test_register_extremes();
    settle();
    load_view(0, 64, 0, 0, 16384, 0);
    repeat (15) send_render();
    settle();
    load_view(64, 0, 0, 0, 0, 16384);
    repeat (15) send_render();
    settle();
    load_view(127, 127, 16383, 16383, -16384, 16384);
    fill_window();
    repeat (40) send_render();
    settle();
    load_view(1, 1, 0, 0, 16384, -16384);
    fill_window();
    repeat (20) send_render();
    settle();
    load_view(64, 64, 8192, 8192, -16384, -16384);
    fill_window();
    repeat (40) send_render();
    settle();
    load_view(12, 12, 1536, 1536, 0, 0);     // everything collapses onto the player cell
    fill_window();
    repeat (15) send_render();
  endtask

  // results held back long enough for the block to fill and stop taking requests
  task automatic test_backpressure();
    settle();
    load_view(8, 8, 1024, 1024, 11585, 11585);
    fill_window();
    tx_idle_en = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (60) send_render();
    tx_idle_en = 1'b1;
  endtask

  // many views in a row, each with its reachable cells filled first
  task automatic test_random_views();
    int start, pick, w, h, wuse, huse, px, py, c, s, n;
    real ang;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        w = 64;
        h = 64;
      end else if (pick < 10) begin
        w = $urandom_range(65, 127);
        h = $urandom_range(1, 12);
      end else if (pick < 14) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        h = (w == 0) ? $urandom_range(0, 12) : 0;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
      wuse = (w > MAP_DIM_MAX) ? MAP_DIM_MAX : w;
      huse = (h > MAP_DIM_MAX) ? MAP_DIM_MAX : h;
      // player mostly over the map in use, now and then anywhere
      if ($urandom_range(0, 9) == 0 || wuse == 0 || huse == 0) begin
        px = $urandom_range(0, 16383);
        py = $urandom_range(0, 16383);
      end else begin
        px = $urandom_range(0, wuse * 256 - 1);
        py = $urandom_range(0, huse * 256 - 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // a real rotation
        ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        c = $rtoi($floor(16384.0 * $cos(ang) + 0.5));
        s = $rtoi($floor(16384.0 * $sin(ang) + 0.5));
      end else if (pick < 80) begin
        c = int'($urandom_range(0, 32768)) - 16384;
        s = int'($urandom_range(0, 32768)) - 16384;
      end else begin
        c = (int'($urandom_range(0, 2)) - 1) * 16384;
        s = (int'($urandom_range(0, 2)) - 1) * 16384;
      end
      load_view(w, h, px, py, c, s);
      fill_window();
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      n = $urandom_range(30, 120);
      repeat (n) begin
        if ($urandom_range(0, 99) < 85) begin
          send_render();
        end else if (wuse > 0 && huse > 0 && $urandom_range(0, 9) < 7) begin
          send_cell_write(CELL_W'($urandom_range(0, wuse - 1)),
                          CELL_W'($urandom_range(0, huse - 1)), KIND_W'($urandom));
        end else begin
          send_cell_write(CELL_W'($urandom), CELL_W'($urandom), KIND_W'($urandom));
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_streaming_tail();
    settle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    load_view(12, 12, 1664, 1664, 14189, 8192);
    fill_window();
    repeat (200) begin
      if ($urandom_range(0, 9) == 0)
        send_cell_write(CELL_W'($urandom_range(0, 11)), CELL_W'($urandom_range(0, 11)),
                        KIND_W'($urandom));
      else
        send_render();
    end
  endtask

  initial begin
    // reset values of the view registers
    view_cfg.map_width = 7'd64;
    view_cfg.map_height = 7'd64;
    view_cfg.player_x = '0;
    view_cfg.player_y = '0;
    view_cfg.cos_angle = 16'sd16384;
    view_cfg.sin_angle = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_lookup();
    test_register_extremes();
    test_backpressure();
    test_random_views();
    test_streaming_tail();

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rcts_pkg.sv
hw/rtl/rcts_front.sv
hw/rtl/rcts_queue.sv
hw/rtl/rcts_back.sv
hw/rtl/rotated_circular_tilemap_sampler_unit.sv
tb/sv/tb_top.sv
